### sv/assert_macros.svh
// Assertion macros shared by the timer table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define TTOP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer table assertion failed");

// Next-cycle implication, checked on clk, off while rst_n is low.
`define TTOP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer table assertion failed");

`endif

### sv/ttop_pkg.sv
// Types and constants of the timer table.
`timescale 1ns / 1ps
package ttop_pkg;

  localparam int NUM_TIMERS_DEF = 16;

  localparam int MODE_W   = 3;
  localparam int TIDX_W   = 8;
  localparam int FLAGS_W  = 2;
  localparam int TIME_W   = 64;
  localparam int STATUS_W = 2;
  localparam int RIDX_W   = 6;

  localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_START   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_STOP    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_IDX = 2'd2;

  localparam int FLAG_ENABLE   = 0;
  localparam int FLAG_PERIODIC = 1;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_ALLOC,
    OP_START,
    OP_STOP,
    OP_RELEASE,
    OP_QUERY,
    OP_NOP,
    OP_BAD_IDX
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [RIDX_W-1:0]  idx;
    logic [FLAGS_W-1:0] flags;
    logic [TIME_W-1:0]  interval;
    logic [TIME_W-1:0]  now;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                fired;
    logic [RIDX_W-1:0]   idx;
    logic [TIME_W-1:0]   elapsed;
    logic                last;
  } res_t;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

endpackage

### sv/ttop_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ttop_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we_i) begin
      mem_r[waddr_i] <= wdata_i;
    end
    rdata_r <= mem_r[raddr_i];
  end

  assign rdata_o = rdata_r;

endmodule

### sv/ttop_fifo.sv
// Small generic FIFO used for the command and result queues.
`timescale 1ns / 1ps
module ttop_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full_o  = (cnt_r == CNT_W'(DEPTH));
  assign empty_o = (cnt_r == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata_i;
    end
  end

endmodule

### sv/ttop_front.sv
// Front end: accepts input transactions, classifies them, queues commands.
`timescale 1ns / 1ps
module ttop_front #(
  parameter int NUM_TIMERS = ttop_pkg::NUM_TIMERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [ttop_pkg::MODE_W-1:0]  in_mode,
  input  logic [ttop_pkg::TIDX_W-1:0]  in_timer_index,
  input  logic [ttop_pkg::FLAGS_W-1:0] in_add_flags,
  input  logic [ttop_pkg::TIME_W-1:0]  in_interval_us,
  input  logic [ttop_pkg::TIME_W-1:0]  in_now_us,
  output ttop_pkg::cmd_t              cmd_o,
  output logic                        cmd_valid_o,
  input  logic                        cmd_pop_i
);
  import ttop_pkg::*;

  cmd_t             cmd_in;
  logic             idx_ok;
  logic [CMD_W-1:0] q_rdata;
  logic             q_empty;

  assign idx_ok = ({1'b0, in_timer_index} < (TIDX_W + 1)'(NUM_TIMERS));

  always_comb begin
    cmd_in.idx      = in_timer_index[RIDX_W-1:0];
    cmd_in.flags    = in_add_flags;
    cmd_in.interval = in_interval_us;
    cmd_in.now      = in_now_us;
    case (in_mode)
      MODE_TICK:    cmd_in.op = OP_TICK;
      MODE_ALLOC:   cmd_in.op = OP_ALLOC;
      MODE_START:   cmd_in.op = OP_START;
      MODE_STOP:    cmd_in.op = OP_STOP;
      MODE_RELEASE: cmd_in.op = OP_RELEASE;
      MODE_QUERY:   cmd_in.op = OP_QUERY;
      default:      cmd_in.op = OP_NOP;
    endcase
    if ((in_mode inside {MODE_START, MODE_STOP, MODE_RELEASE, MODE_QUERY}) && !idx_ok) begin
      cmd_in.op = OP_BAD_IDX;
    end
  end

  ttop_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(2)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (in_push),
    .wdata_i (cmd_in),
    .full_o  (in_full),
    .pop_i   (cmd_pop_i),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  assign cmd_o       = cmd_t'(q_rdata);
  assign cmd_valid_o = !q_empty;

endmodule

### sv/ttop_back.sv
// Back end: timer slot state, command sequencer and result queue.
`timescale 1ns / 1ps
module ttop_back #(
  parameter int NUM_TIMERS = ttop_pkg::NUM_TIMERS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  ttop_pkg::cmd_t cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_pop_o,
  output ttop_pkg::res_t res_o,
  output logic           res_empty_o,
  input  logic           res_pop_i
);
  import ttop_pkg::*;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_QUERY,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t                  state_r, state_nxt;
  logic [IDX_W-1:0]        ptr_r, ptr_nxt;
  logic [NUM_TIMERS-1:0]   in_use_r, in_use_nxt;
  logic [NUM_TIMERS-1:0]   enabled_r, enabled_nxt;
  logic [NUM_TIMERS-1:0]   periodic_r, periodic_nxt;
  logic [NUM_TIMERS-1:0]   stv_r, stv_nxt;
  logic                    pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0]        pend_idx_r, pend_idx_nxt;
  res_t                    res_r, res_nxt;
  cmd_t                    cur_r, cur_nxt;

  logic                    st_we, iv_we;
  logic [IDX_W-1:0]        raddr;
  logic [TIME_W-1:0]       st_rdata, iv_rdata, st_val, elapsed;
  logic                    expired, need_push;
  logic                    res_push, res_full;
  res_t                    res_wdata;
  logic [RES_W-1:0]        res_q;
  logic [IDX_W-1:0]        cidx;

  function automatic res_t fired_res(input logic [IDX_W-1:0] idx, input logic last);
    res_t r;
    r.status  = ST_OK;
    r.fired   = 1'b1;
    r.idx     = RIDX_W'(idx);
    r.elapsed = '0;
    r.last    = last;
    return r;
  endfunction

  assign cidx    = cmd_i.idx[IDX_W-1:0];
  assign st_val  = stv_r[ptr_r] ? st_rdata : '0;
  assign elapsed = cur_r.now - st_val;
  assign expired = in_use_r[ptr_r] && enabled_r[ptr_r] && (elapsed >= iv_rdata);

  always_comb begin
    state_nxt    = state_r;
    ptr_nxt      = ptr_r;
    in_use_nxt   = in_use_r;
    enabled_nxt  = enabled_r;
    periodic_nxt = periodic_r;
    stv_nxt      = stv_r;
    pend_v_nxt   = pend_v_r;
    pend_idx_nxt = pend_idx_r;
    res_nxt      = res_r;
    cur_nxt      = cur_r;
    cmd_pop_o    = 1'b0;
    res_push     = 1'b0;
    res_wdata    = res_r;
    st_we        = 1'b0;
    iv_we        = 1'b0;
    raddr        = ptr_r;
    need_push    = expired && pend_v_r;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o       = 1'b1;
          cur_nxt         = cmd_i;
          res_nxt.status  = ST_OK;
          res_nxt.fired   = 1'b0;
          res_nxt.idx     = '0;
          res_nxt.elapsed = '0;
          res_nxt.last    = 1'b1;
          state_nxt       = S_EMIT;
          case (cmd_i.op)
            OP_TICK: begin
              raddr      = '0;
              ptr_nxt    = '0;
              pend_v_nxt = 1'b0;
              state_nxt  = S_SCAN;
            end
            OP_ALLOC: begin
              ptr_nxt   = '0;
              state_nxt = S_ALLOC;
            end
            OP_START: begin
              if (in_use_r[cidx]) enabled_nxt[cidx] = 1'b1;
            end
            OP_STOP: begin
              if (in_use_r[cidx]) enabled_nxt[cidx] = 1'b0;
            end
            OP_RELEASE: begin
              in_use_nxt[cidx]   = 1'b0;
              enabled_nxt[cidx]  = 1'b0;
              periodic_nxt[cidx] = 1'b0;
            end
            OP_QUERY: begin
              raddr     = cidx;
              ptr_nxt   = cidx;
              state_nxt = S_QUERY;
            end
            OP_BAD_IDX: begin
              res_nxt.status = ST_BAD_IDX;
            end
            default: begin
            end
          endcase
        end
      end

      S_ALLOC: begin
        if (!in_use_r[ptr_r]) begin
          in_use_nxt[ptr_r]   = 1'b1;
          enabled_nxt[ptr_r]  = cur_r.flags[FLAG_ENABLE];
          periodic_nxt[ptr_r] = cur_r.flags[FLAG_PERIODIC];
          stv_nxt[ptr_r]      = 1'b1;
          st_we               = 1'b1;
          iv_we               = 1'b1;
          res_nxt.idx         = RIDX_W'(ptr_r);
          state_nxt           = S_EMIT;
        end else if (ptr_r == LAST_IDX) begin
          res_nxt.status = ST_NO_FREE;
          state_nxt      = S_EMIT;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end

      S_QUERY: begin
        res_nxt.elapsed = elapsed;
        state_nxt       = S_EMIT;
      end

      S_SCAN: begin
        // the previous expiry waits in pend until it is known whether it is last
        if (!(need_push && res_full)) begin
          if (need_push) begin
            res_push  = 1'b1;
            res_wdata = fired_res(pend_idx_r, 1'b0);
          end
          if (expired) begin
            pend_v_nxt   = 1'b1;
            pend_idx_nxt = ptr_r;
            if (periodic_r[ptr_r]) begin
              st_we          = 1'b1;
              stv_nxt[ptr_r] = 1'b1;
            end else begin
              enabled_nxt[ptr_r] = 1'b0;
            end
          end
          if (ptr_r == LAST_IDX) begin
            if (expired) begin
              res_nxt = fired_res(ptr_r, 1'b1);
            end else if (pend_v_r) begin
              res_nxt = fired_res(pend_idx_r, 1'b1);
            end
            state_nxt = S_EMIT;
          end else begin
            ptr_nxt = ptr_r + 1'b1;
            raddr   = ptr_r + 1'b1;
          end
        end
      end

      S_EMIT: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_use_r   <= '0;
      enabled_r  <= '0;
      periodic_r <= '0;
      stv_r      <= '0;
      pend_v_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_use_r   <= in_use_nxt;
      enabled_r  <= enabled_nxt;
      periodic_r <= periodic_nxt;
      stv_r      <= stv_nxt;
      pend_v_r   <= pend_v_nxt;
    end
    ptr_r      <= ptr_nxt;
    pend_idx_r <= pend_idx_nxt;
    res_r      <= res_nxt;
    cur_r      <= cur_nxt;
  end

  ttop_ram #(
    .WIDTH(TIME_W),
    .DEPTH(NUM_TIMERS)
  ) u_start_ram (
    .clk     (clk),
    .we_i    (st_we),
    .waddr_i (ptr_r),
    .wdata_i (cur_r.now),
    .raddr_i (raddr),
    .rdata_o (st_rdata)
  );

  ttop_ram #(
    .WIDTH(TIME_W),
    .DEPTH(NUM_TIMERS)
  ) u_interval_ram (
    .clk     (clk),
    .we_i    (iv_we),
    .waddr_i (ptr_r),
    .wdata_i (cur_r.interval),
    .raddr_i (raddr),
    .rdata_o (iv_rdata)
  );

  ttop_fifo #(
    .WIDTH(RES_W),
    .DEPTH(2)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (res_push),
    .wdata_i (res_wdata),
    .full_o  (res_full),
    .pop_i   (res_pop_i),
    .rdata_o (res_q),
    .empty_o (res_empty_o)
  );

  assign res_o = res_t'(res_q);

endmodule

### sv/timer_table_one_shot_periodic.sv
// Top level of the one-shot / periodic timer table.
// A table of NUM_TIMERS timer slots driven through two queue-style ports.
// Each input transaction carries a mode (tick, allocate, start, stop, release,
// query) and gives one result, except a tick, which gives one result per
// expired slot in index order (or a single fired=0 result), with last marking
// the final one. Commands pass a two-entry queue into a sequencer that owns the
// slot flags and two RAMs (start time, interval) sharing one read address;
// results leave through a two-entry queue. A tick scans the slots through the RAM
// read port at one slot per cycle while the result queue is not full; an allocate
// searches for a free slot at one slot per cycle; a query waits for the RAM read.
// Commands are registered in the front queue before the sequencer sees them.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module timer_table_one_shot_periodic #(
  parameter int NUM_TIMERS = ttop_pkg::NUM_TIMERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [ttop_pkg::MODE_W-1:0]   in_mode,
  input  logic [ttop_pkg::TIDX_W-1:0]   in_timer_index,
  input  logic [ttop_pkg::FLAGS_W-1:0]  in_add_flags,
  input  logic [ttop_pkg::TIME_W-1:0]   in_interval_us,
  input  logic [ttop_pkg::TIME_W-1:0]   in_now_us,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [ttop_pkg::STATUS_W-1:0] out_status,
  output logic                          out_fired,
  output logic [ttop_pkg::RIDX_W-1:0]   out_timer_index_res,
  output logic [ttop_pkg::TIME_W-1:0]   out_elapsed_us,
  output logic                          out_last
);
  import ttop_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;
  res_t res;

  ttop_front #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_mode        (in_mode),
    .in_timer_index (in_timer_index),
    .in_add_flags   (in_add_flags),
    .in_interval_us (in_interval_us),
    .in_now_us      (in_now_us),
    .cmd_o          (cmd),
    .cmd_valid_o    (cmd_valid),
    .cmd_pop_i      (cmd_pop)
  );

  ttop_back #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res),
    .res_empty_o (out_empty),
    .res_pop_i   (out_pop)
  );

  assign out_status          = res.status;
  assign out_fired           = res.fired;
  assign out_timer_index_res = res.idx;
  assign out_elapsed_us      = res.elapsed;
  assign out_last            = res.last;

  `TTOP_ASSERT_IMP(a_fired_ok, !out_empty && out_fired, out_status == ST_OK && out_elapsed_us == '0)
  `TTOP_ASSERT_IMP(a_err_clean, !out_empty && out_status != ST_OK, out_timer_index_res == '0 && !out_fired)
  `TTOP_ASSERT_IMP(a_pop_valid, cmd_pop, cmd_valid)
  `TTOP_ASSERT_NEXT(a_cmd_held, cmd_valid && !cmd_pop, cmd_valid)

endmodule
